@@ sv/obfp_pkg.sv @@
// Types and constants shared by the offset bit-field packer.
package obfp_pkg;

	localparam int unsigned RankW  = 8;
	localparam int unsigned DepthW = 4;
	localparam int unsigned CntW   = 3;
	localparam int unsigned MaxDepth = 8;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_FIELD_DEPTH = 1'b0,
		CFG_RANK_BASE   = 1'b1
	} cfg_index_t;

	localparam logic [DepthW-1:0] DepthReset = DepthW'(1);
	localparam logic [RankW-1:0]  BaseReset  = '0;

	typedef struct packed {
		logic [RankW-1:0] rank_value;
		logic             last_rank;
	} rank_req_t;

	typedef struct packed {
		logic [RankW-1:0] packed_byte;
		logic             last_byte;
	} byte_res_t;

	// results of one packing step
	typedef struct packed {
		logic [1:0] count;
		byte_res_t  first;
		byte_res_t  second;
	} pack_out_t;

endpackage

@@ sv/obfp_pack.sv @@
// Packing step: field extraction, accumulation and pending-bit state.
module obfp_pack import obfp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  rank_req_t         req,
	input  logic [DepthW-1:0] field_depth,
	input  logic [RankW-1:0]  rank_base,
	output pack_out_t         res
);

	logic [CntW+3:0]   pend_bits_q;
	logic [CntW-1:0]   pend_cnt_q;
	logic [DepthW-1:0] depth;
	logic [RankW-1:0]  mask;
	logic [RankW-1:0]  field;
	logic [14:0]       acc;
	logic [DepthW-1:0] total;
	logic              full;
	logic [14:0]       rem_acc;
	logic [CntW-1:0]   rem_total;
	logic [RankW-1:0]  part_mask;
	logic              has_part;
	byte_res_t         full_res;
	byte_res_t         part_res;

	always_comb begin
		if (field_depth == '0) begin
			depth = DepthW'(1);
		end else if (field_depth > DepthW'(MaxDepth)) begin
			depth = DepthW'(MaxDepth);
		end else begin
			depth = field_depth;
		end
		mask      = RankW'((9'(1) << depth) - 9'(1));
		field     = (req.rank_value - rank_base) & mask;
		acc       = {8'b0, pend_bits_q} | (15'(field) << pend_cnt_q);
		total     = DepthW'(pend_cnt_q) + depth;
		full      = total >= DepthW'(8);
		rem_acc   = full ? (acc >> 8) : acc;
		rem_total = full ? CntW'(total - DepthW'(8)) : CntW'(total);
		has_part  = req.last_rank && (rem_total != '0);
		part_mask = RankW'((9'(1) << rem_total) - 9'(1));

		full_res.packed_byte = acc[7:0];
		full_res.last_byte   = req.last_rank && (rem_total == '0);
		part_res.packed_byte = rem_acc[7:0] & part_mask;
		part_res.last_byte   = 1'b1;

		res.count  = 2'(full) + 2'(has_part);
		res.first  = full ? full_res : part_res;
		res.second = part_res;
	end

	// hold leftover bits between ranks; drop them after the last rank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else if (step) begin
			if (req.last_rank) begin
				pend_bits_q <= '0;
				pend_cnt_q  <= '0;
			end else begin
				pend_bits_q <= rem_acc[6:0];
				pend_cnt_q  <= rem_total;
			end
		end
	end

endmodule

@@ sv/obfp_fifo.sv @@
// Four-entry result queue taking up to two results per cycle.
module obfp_fifo import obfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  pack_out_t wr,
	output logic      room2,
	output logic      out_valid,
	input  logic      out_ready,
	output byte_res_t out_item
);

	byte_res_t   mem_q [4];
	logic [1:0]  wr_ptr_q;
	logic [1:0]  rd_ptr_q;
	logic [2:0]  cnt_q;
	logic [1:0]  n_push;
	logic        pop;

	assign n_push    = push ? wr.count : 2'd0;
	assign pop       = out_valid && out_ready;
	assign out_valid = cnt_q != '0;
	assign out_item  = mem_q[rd_ptr_q];
	assign room2     = cnt_q <= 3'd2;

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem_q[wr_ptr_q] <= wr.first;
		end
		if (n_push == 2'd2) begin
			mem_q[wr_ptr_q + 2'd1] <= wr.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push;
			rd_ptr_q <= rd_ptr_q + 2'(pop);
			cnt_q    <= cnt_q + 3'(n_push) - 3'(pop);
		end
	end

endmodule

@@ sv/offset_bit_field_packer.sv @@
// Top level of the offset bit-field packer.
//
// Usage: ranks arrive as requests on the in_valid/in_ready channel. Each rank
// has rank_base subtracted (mod 256) and its low field_depth bits are packed
// LSB-first into bytes, which leave on the out_valid/out_ready channel. A rank
// marked last_rank flushes any partial byte (upper bits zero) and tags the
// final byte with last_byte.
// Configuration: cfg_wr_en with cfg_index 0 writes field_depth (0 acts as 1,
// above 8 acts as 8), index 1 writes rank_base. Write only while idle.
// Path: the input register takes a rank at the edge that accepts it, and the
// packing step writes its bytes into the result queue once the queue has room
// for two bytes; out_valid is high while the queue holds a byte.
// Throughput: one rank per cycle while not stalled; a rank yields at most two
// bytes, and the four-entry result queue absorbs the extra byte of a flush.
// Stall: when the receiver holds out_ready low, the queue fills, the input
// register stops advancing and in_ready drops; nothing is lost.
// Reset: arst_n clears pending bits, the queue and the input valid flag, and
// restores field_depth to 1 and rank_base to 0.
module offset_bit_field_packer import obfp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rank_req_t         in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output byte_res_t         out_item,
	input  logic              cfg_wr_en,
	input  cfg_index_t        cfg_index,
	input  logic [RankW-1:0]  cfg_wr_data
);

	logic              valid_s1;
	rank_req_t         req_s1;
	logic [DepthW-1:0] depth_q;
	logic [RankW-1:0]  base_q;
	logic              room2;
	logic              step;
	pack_out_t         pack_res;

	// advance the held request once the queue can take two bytes
	assign step     = valid_s1 && room2;
	assign in_ready = !valid_s1 || step;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DepthReset;
			base_q  <= BaseReset;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_FIELD_DEPTH: depth_q <= cfg_wr_data[DepthW-1:0];
				CFG_RANK_BASE:   base_q  <= cfg_wr_data;
				default:         base_q  <= base_q;
			endcase
		end
	end

	// input register: valid needs reset, payload does not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= in_item;
		end
	end

	obfp_pack u_pack (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.req         (req_s1),
		.field_depth (depth_q),
		.rank_base   (base_q),
		.res         (pack_res)
	);

	obfp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step),
		.wr        (pack_res),
		.room2     (room2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
